// File: rtl/core/mgsa_pkg.sv
package mgsa_pkg;

    // Widths fixed by the item fields and the register
    localparam int SEAT_W   = 6;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // Command carried on the input side-band
    typedef enum logic {
        CMD_TAKE    = 1'b0,
        CMD_RELEASE = 1'b1
    } cmd_t;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_OCC = 2'd2;

    // Register index (byte address bit 2) and reset value
    localparam logic                 REG_SEAT_COUNT   = 1'b0;
    localparam logic [COUNT_W-1:0]   SEAT_COUNT_RESET = 7'd64;

    // Broadcast control for the ring of occupancy cells
    typedef struct packed {
        logic shift;
        logic set_bit;
        logic clr_bit;
    } cell_ctl_t;

    // Summary flags of one scan pass
    typedef struct packed {
        logic any_free;
        logic seen_occ;
    } scan_stat_t;

endpackage

// File: rtl/core/mgsa_cell.sv
module mgsa_cell #(
    parameter int IW  = 6,
    parameter int POS = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  mgsa_pkg::cell_ctl_t ctl,
    input  logic [IW-1:0]       wr_idx,
    input  logic                shift_in,
    output logic                occ
);
    import mgsa_pkg::*;

    localparam logic [IW-1:0] MY_POS = IW'(POS);

    logic occ_reg;
    logic occ_next;

    // Rotate with the ring, or take a set/clear aimed at this position
    always_comb begin
        occ_next = occ_reg;
        if (ctl.shift) begin
            occ_next = shift_in;
        end else if (wr_idx == MY_POS) begin
            if (ctl.set_bit) begin
                occ_next = 1'b1;
            end else if (ctl.clr_bit) begin
                occ_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    assign occ = occ_reg;

endmodule

// File: rtl/core/mgsa_scan.sv
module mgsa_scan #(
    parameter int IW = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 clear,
    input  logic                 step_en,
    input  logic                 step_last,
    input  logic [IW-1:0]        pos,
    input  logic                 occ_bit,
    output mgsa_pkg::scan_stat_t stat,
    output logic [IW-1:0]        best_idx
);
    import mgsa_pkg::*;

    logic          any_free_reg, any_free_next;
    logic          seen_reg, seen_next;
    logic          found_reg, found_next;
    logic [IW-1:0] last_reg, last_next;
    logic [IW-1:0] best_idx_reg, best_idx_next;
    logic [IW-1:0] best_dist_reg, best_dist_next;

    logic [IW-1:0] gap;
    logic [IW-1:0] half;
    logic          cand_v;
    logic [IW-1:0] cand_idx;
    logic [IW-1:0] cand_dist;

    // Candidate slot for this position: leading edge, middle of a gap, or trailing edge
    always_comb begin
        gap       = pos - last_reg;
        half      = gap >> 1;
        cand_v    = 1'b0;
        cand_idx  = '0;
        cand_dist = '0;
        if (occ_bit) begin
            if (!seen_reg) begin
                if (pos != '0) begin
                    cand_v    = 1'b1;
                    cand_idx  = '0;
                    cand_dist = pos;
                end
            end else if (gap > IW'(1)) begin
                cand_v    = 1'b1;
                cand_idx  = last_reg + half;
                cand_dist = half;
            end
        end else if (step_last && seen_reg) begin
            cand_v    = 1'b1;
            cand_idx  = pos;
            cand_dist = gap;
        end
    end

    // Keep the first strictly larger distance so ties stay at the lower slot
    always_comb begin
        any_free_next  = any_free_reg;
        seen_next      = seen_reg;
        found_next     = found_reg;
        last_next      = last_reg;
        best_idx_next  = best_idx_reg;
        best_dist_next = best_dist_reg;
        if (clear) begin
            any_free_next = 1'b0;
            seen_next     = 1'b0;
            found_next    = 1'b0;
        end else if (step_en) begin
            if (occ_bit) begin
                seen_next = 1'b1;
                last_next = pos;
            end else begin
                any_free_next = 1'b1;
            end
            if (cand_v && (!found_reg || cand_dist > best_dist_reg)) begin
                found_next     = 1'b1;
                best_idx_next  = cand_idx;
                best_dist_next = cand_dist;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            any_free_reg <= 1'b0;
            seen_reg     <= 1'b0;
            found_reg    <= 1'b0;
        end else begin
            any_free_reg <= any_free_next;
            seen_reg     <= seen_next;
            found_reg    <= found_next;
        end
        last_reg      <= last_next;
        best_idx_reg  <= best_idx_next;
        best_dist_reg <= best_dist_next;
    end

    assign stat.any_free = any_free_reg;
    assign stat.seen_occ = seen_reg;
    assign best_idx      = best_idx_reg;

endmodule

// File: rtl/core/max_gap_slot_allocator_core.sv
// Max-gap slot allocator.
// Input stream: s_tuser carries the command (take or release), s_tdata the
// slot to release. Each transfer yields exactly one result on the master
// stream: the granted or echoed slot and a status (ok, row full, slot was
// not occupied).
// The occupancy map lives in a ring of NUM_SEATS one-bit cells. Every item
// rotates the ring once around, so that each slot passes the scan unit at
// the head; after the rotation the ring is back in place, and the commit state
// sets or clears the chosen cell and loads the result register.
// A new item is accepted only after the previous one has left the commit state.
// The result register holds while the receiver stalls; the next item is still
// accepted, and its result waits only if the previous one has not been taken by
// the end of its rotation. Reset (aresetn low, synchronous) empties the row and
// sets seat_count to 64. seat_count is written over the APB port at address 0;
// the user must write it only while the block is idle, as the block itself
// does not enforce this.
module max_gap_slot_allocator_core #(
    parameter int NUM_SEATS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Command stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [5:0] seat_index, [7:6] zero
    input  logic [0:0]  s_tuser,   // [0] command
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [5:0] seat, [7:6] status
);
    import mgsa_pkg::*;

    localparam int IW = (NUM_SEATS > 1) ? $clog2(NUM_SEATS) : 1;
    localparam int CW = $clog2(NUM_SEATS + 1);
    localparam int XW = (CW > SEAT_W) ? CW : SEAT_W;
    localparam int MW = (CW > COUNT_W) ? CW : COUNT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } state_t;

    state_t                state_reg, state_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [SEAT_W-1:0]     seat_out_reg, seat_out_next;
    logic [STATUS_W-1:0]   status_out_reg, status_out_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [SEAT_W-1:0]     idx_reg, idx_next;
    logic [IW-1:0]         step_reg, step_next;
    logic [IW-1:0]         row_last_reg, row_last_next;
    logic                  hit_reg, hit_next;
    logic [COUNT_W-1:0]    seat_count_reg;

    logic [CW-1:0]         row_size;
    logic                  in_xfer;
    logic                  out_free;
    logic                  idx_hit;
    logic [NUM_SEATS-1:0]  occ;
    cell_ctl_t             cell_ctl;
    logic [IW-1:0]         wr_idx;
    logic [IW-1:0]         grant_idx;
    logic                  scan_clear;
    logic                  step_en;
    logic                  step_last;
    scan_stat_t            scan_stat;
    logic [IW-1:0]         best_idx;

    // Configuration register
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seat_count_reg <= SEAT_COUNT_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_SEAT_COUNT) begin
            seat_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_SEAT_COUNT) ? 32'(seat_count_reg) : 32'd0;

    // Clamp the row size to 1..NUM_SEATS
    always_comb begin
        if (seat_count_reg == '0) begin
            row_size = CW'(1);
        end else if (MW'(seat_count_reg) > MW'(NUM_SEATS)) begin
            row_size = CW'(NUM_SEATS);
        end else begin
            row_size = CW'(seat_count_reg);
        end
    end

    // Ring of occupancy cells, rotating toward cell 0
    genvar k;
    generate
        for (k = 0; k < NUM_SEATS; k++) begin : g_cell
            mgsa_cell #(
                .IW  (IW),
                .POS (k)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctl      (cell_ctl),
                .wr_idx   (wr_idx),
                .shift_in (occ[(k + 1) % NUM_SEATS]),
                .occ      (occ[k])
            );
        end
    endgenerate

    // Scan unit watching the head of the ring
    assign step_en   = (state_reg == ST_SCAN) && (step_reg <= row_last_reg);
    assign step_last = (step_reg == row_last_reg);

    mgsa_scan #(
        .IW (IW)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear     (scan_clear),
        .step_en   (step_en),
        .step_last (step_last),
        .pos       (step_reg),
        .occ_bit   (occ[0]),
        .stat      (scan_stat),
        .best_idx  (best_idx)
    );

    assign in_xfer    = s_tvalid && s_tready;
    assign scan_clear = in_xfer;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign idx_hit    = (XW'(step_reg) == XW'(idx_reg));
    assign grant_idx  = scan_stat.seen_occ ? best_idx : '0;
    assign wr_idx     = (cmd_reg == CMD_TAKE) ? grant_idx : IW'(idx_reg);

    // Cell control: rotate while scanning, then set or clear one cell
    always_comb begin
        cell_ctl.shift   = (state_reg == ST_SCAN);
        cell_ctl.set_bit = (state_reg == ST_FIN) && out_free && (cmd_reg == CMD_TAKE)
                           && scan_stat.any_free;
        cell_ctl.clr_bit = (state_reg == ST_FIN) && out_free && (cmd_reg == CMD_RELEASE)
                           && hit_reg;
    end

    // Sequencer: accept, rotate once around, commit and present the result
    always_comb begin
        state_next      = state_reg;
        m_tvalid_next   = m_tvalid_reg;
        seat_out_next   = seat_out_reg;
        status_out_next = status_out_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        step_next       = step_reg;
        row_last_next   = row_last_reg;
        hit_next        = hit_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    cmd_next      = cmd_t'(s_tuser[0]);
                    idx_next      = s_tdata[SEAT_W-1:0];
                    step_next     = '0;
                    row_last_next = IW'(row_size - CW'(1));
                    hit_next      = 1'b0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (idx_hit && occ[0]) begin
                    hit_next = 1'b1;
                end
                if (step_reg == IW'(NUM_SEATS - 1)) begin
                    state_next = ST_FIN;
                end else begin
                    step_next = step_reg + IW'(1);
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    if (cmd_reg == CMD_TAKE) begin
                        if (scan_stat.any_free) begin
                            seat_out_next   = SEAT_W'(grant_idx);
                            status_out_next = STATUS_OK;
                        end else begin
                            seat_out_next   = '0;
                            status_out_next = STATUS_FULL;
                        end
                    end else begin
                        seat_out_next   = idx_reg;
                        status_out_next = hit_reg ? STATUS_OK : STATUS_NOT_OCC;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        seat_out_reg   <= seat_out_next;
        status_out_reg <= status_out_next;
        cmd_reg        <= cmd_next;
        idx_reg        <= idx_next;
        step_reg       <= step_next;
        row_last_reg   <= row_last_next;
        hit_reg        <= hit_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {status_out_reg, seat_out_reg};

`ifndef SYNTHESIS
    // One item at a time: no transfer right after a transfer
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in progress");

    // A row-full result carries seat zero
    a_full_seat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[7:6] == STATUS_FULL) |-> (m_tdata[5:0] == '0))
        else $error("row-full result with nonzero seat");

    // Results appear only out of the commit cycle
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_FIN))
        else $error("result raised outside the commit cycle");

    // Commit only after a full rotation of the ring
    a_full_turn: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && state_next == ST_FIN) |-> (step_reg == IW'(NUM_SEATS - 1)))
        else $error("ring left out of alignment at commit");
`endif

endmodule
